>>> rtl/jafr_pkg.sv
// Package: field widths, codes and helpers for the joint angle frame receiver.
`default_nettype none
package jafr_pkg;

    localparam int JOINT_COUNT = 8;
    localparam int JIDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    localparam int OPCODE_W = 2;
    localparam int BYTE_W = 8;
    localparam int ID_W = 5;
    localparam int ANGLE_W = 21;
    localparam int LOW_W = 14;
    localparam int TICK_W = 32;
    localparam int TIMEOUT_W = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [OPCODE_W-1:0] OP_RX = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [BYTE_W-1:0] HDR_MARK = 8'h80;
    localparam logic [BYTE_W-1:0] ID_MASK = 8'h7C;

    localparam logic [0:0] REG_TIMEOUT = 1'b0;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

    localparam logic [1:0] PH_HDR = 2'd0;
    localparam logic [1:0] PH_D0 = 2'd1;
    localparam logic [1:0] PH_D1 = 2'd2;
    localparam logic [1:0] PH_D2 = 2'd3;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [TICK_W-1:0]  stamp;
    } entry_t;

    function automatic logic id_ok(input logic [ID_W-1:0] id);
        return (id != '0) && (id <= ID_W'(JOINT_COUNT));
    endfunction

    function automatic logic [JIDX_W-1:0] idx_of(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] t;
        t = id - ID_W'(1);
        return t[JIDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/jafr_in_if.sv
// Interface: input item channel (byte, tick or query).
`default_nettype none
interface jafr_in_if;
    import jafr_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BYTE_W-1:0]   rx_byte;
    logic [ID_W-1:0]     query_joint;

    modport source (output valid, output opcode, output rx_byte, output query_joint,
                    input ready);
    modport sink (input valid, input opcode, input rx_byte, input query_joint,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/jafr_out_if.sv
// Interface: result item channel (stored frame or query answer).
`default_nettype none
interface jafr_out_if;
    import jafr_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [ID_W-1:0]    joint_id;
    logic [ANGLE_W-1:0] raw_angle;
    logic               angle_valid;
    logic [TICK_W-1:0]  last_seen;

    modport source (output valid, output kind, output joint_id, output raw_angle,
                    output angle_valid, output last_seen, input ready);
    modport sink (input valid, input kind, input joint_id, input raw_angle,
                  input angle_valid, input last_seen, output ready);
endinterface
`default_nettype wire

>>> rtl/joint_angle_frame_receiver.sv
// Top level: frame parser, joint table memory and query answer pipeline.
`default_nettype none
// One input item is accepted every cycle unless the answer stage holds an
// item that cannot advance. Bytes are parsed into four-byte frames (header
// with bit 7 set and the joint id in bits 6..2, then three 7-bit data bytes,
// lowest first); a complete frame for joints 1..JOINT_COUNT writes angle and
// timestamp into the joint table and yields a result. A query reads the table
// through a registered read port and may directly follow the frame it asks
// about. Per-joint seen bits are cleared by reset, so the table needs no
// clearing pass. A result register behind the answer stage lets input items
// keep flowing while one result waits, until the answer stage fills too.
module joint_angle_frame_receiver (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    jafr_in_if.sink                            item_in,
    jafr_out_if.source                         item_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [jafr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [jafr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [jafr_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready
);
    import jafr_pkg::*;

    logic [TIMEOUT_W-1:0]   timeout_reg;
    logic [1:0]             phase_reg, phase_next;
    logic [ID_W-1:0]        frame_id_reg, frame_id_next;
    logic [LOW_W-1:0]       low_bits_reg, low_bits_next;
    logic [TICK_W-1:0]      now_reg;
    logic [JOINT_COUNT-1:0] seen_reg;
    entry_t                 mem [JOINT_COUNT];

    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_kind_reg;
    logic [ID_W-1:0]        s1_id_reg;
    logic [ANGLE_W-1:0]     s1_raw_reg;
    logic [TICK_W-1:0]      s1_now_reg;
    logic                   s1_seen_reg;
    entry_t                 rd_entry_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg;
    logic [ID_W-1:0]        out_id_reg;
    logic [ANGLE_W-1:0]     out_raw_reg;
    logic                   out_av_reg;
    logic [TICK_W-1:0]      out_seen_reg;

    logic                   in_fire;
    logic                   is_rx;
    logic                   is_query;
    logic                   hdr;
    logic                   frame_done;
    logic [ANGLE_W-1:0]     raw_new;
    logic [JIDX_W-1:0]      widx;
    logic [JIDX_W-1:0]      qidx;
    logic                   s1_adv;
    logic                   s1_load;
    logic [TICK_W-1:0]      age;
    logic                   q_valid;
    logic                   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_TIMEOUT);
    assign prdata = (paddr[APB_ADDR_W-1] == REG_TIMEOUT)
                  ? APB_DATA_W'(timeout_reg) : '0;

    assign s1_adv        = !out_valid_reg || item_out.ready;
    assign item_in.ready = !s1_valid_reg || s1_adv;
    assign in_fire       = item_in.valid && item_in.ready;
    assign is_rx         = in_fire && (item_in.opcode == OP_RX);
    assign is_query      = in_fire && (item_in.opcode == OP_QUERY);
    assign hdr           = (item_in.rx_byte & HDR_MARK) != '0;
    assign raw_new       = {item_in.rx_byte[6:0], low_bits_reg};
    assign widx          = idx_of(frame_id_reg);
    assign qidx          = idx_of(item_in.query_joint);
    assign frame_done    = is_rx && (phase_reg == PH_D2) && !hdr && id_ok(frame_id_reg);
    assign s1_load       = frame_done || is_query;

    always_comb
    begin
        phase_next    = phase_reg;
        frame_id_next = frame_id_reg;
        low_bits_next = low_bits_reg;
        if (is_rx)
        begin
            unique case (phase_reg)
                PH_HDR:
                begin
                    if (hdr)
                    begin
                        frame_id_next = ID_W'((item_in.rx_byte & ID_MASK) >> 2);
                        phase_next    = PH_D0;
                    end
                end
                PH_D0:
                begin
                    phase_next    = hdr ? PH_HDR : PH_D1;
                    if (!hdr)
                        low_bits_next = {7'd0, item_in.rx_byte[6:0]};
                end
                PH_D1:
                begin
                    phase_next    = hdr ? PH_HDR : PH_D2;
                    if (!hdr)
                        low_bits_next = {item_in.rx_byte[6:0], low_bits_reg[6:0]};
                end
                PH_D2:
                begin
                    phase_next = PH_HDR;
                end
                default:
                begin
                    phase_next = PH_HDR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= TIMEOUT_RESET;
            phase_reg    <= PH_HDR;
            frame_id_reg <= '0;
            low_bits_reg <= '0;
            now_reg      <= '0;
            seen_reg     <= '0;
        end
        else
        begin
            if (cfg_wr)
                timeout_reg <= pwdata[TIMEOUT_W-1:0];
            phase_reg    <= phase_next;
            frame_id_reg <= frame_id_next;
            low_bits_reg <= low_bits_next;
            if (in_fire && (item_in.opcode == OP_TICK))
                now_reg <= now_reg + TICK_W'(1);
            if (frame_done)
                seen_reg[widx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_done)
            mem[widx] <= '{angle: raw_new, stamp: now_reg};
    end

    always_ff @(posedge clk)
    begin
        if (is_query)
            rd_entry_reg <= mem[qidx];
    end

    assign s1_valid_next = s1_load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_kind_reg <= frame_done ? KIND_FRAME : KIND_QUERY;
            s1_id_reg   <= frame_done ? frame_id_reg : item_in.query_joint;
            s1_raw_reg  <= raw_new;
            s1_now_reg  <= now_reg;
            s1_seen_reg <= id_ok(item_in.query_joint) && seen_reg[qidx];
        end
    end

    assign age     = s1_now_reg - rd_entry_reg.stamp;
    assign q_valid = s1_seen_reg && (age <= TICK_W'(timeout_reg));

    assign out_valid_next = (s1_valid_reg && s1_adv) ? 1'b1
                          : (item_out.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_adv)
        begin
            out_kind_reg <= s1_kind_reg;
            out_id_reg   <= s1_id_reg;
            if (s1_kind_reg == KIND_FRAME)
            begin
                out_raw_reg  <= s1_raw_reg;
                out_av_reg   <= 1'b1;
                out_seen_reg <= s1_now_reg;
            end
            else
            begin
                out_raw_reg  <= s1_seen_reg ? rd_entry_reg.angle : '0;
                out_av_reg   <= q_valid;
                out_seen_reg <= s1_seen_reg ? rd_entry_reg.stamp : '0;
            end
        end
    end

    assign item_out.valid       = out_valid_reg;
    assign item_out.kind        = out_kind_reg;
    assign item_out.joint_id    = out_id_reg;
    assign item_out.raw_angle   = out_raw_reg;
    assign item_out.angle_valid = out_av_reg;
    assign item_out.last_seen   = out_seen_reg;

    a_query_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
        is_query |=> s1_valid_reg && (s1_kind_reg == KIND_QUERY))
        else $error("query item did not enter the answer stage");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_id_reg))
        else $error("answer stage lost an item under stall");

    a_bad_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        item_out.valid && (item_out.kind == KIND_QUERY) && !id_ok(item_out.joint_id)
        |-> (item_out.raw_angle == '0) && !item_out.angle_valid
            && (item_out.last_seen == '0))
        else $error("query for unknown joint returned data");

    a_seen_set: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> seen_reg[$past(widx)])
        else $error("stored frame did not mark its joint as seen");

endmodule
`default_nettype wire
